>>> hw/rtl/almp_pkg.sv
// ----------------------------------------------------------------------------
// almp_pkg: shared definitions of the attitude limit persistence monitor
// Widths, codes and word types used by the monitor's modules.
// ----------------------------------------------------------------------------
package almp_pkg;

	localparam int CHANNELS        = 6;
	localparam int SAMPLE_WIDTH    = 16;
	localparam int TIMER_WIDTH     = 32;
	localparam int STEP_WIDTH      = 16;
	localparam int SETTING_WIDTH   = SAMPLE_WIDTH + TIMER_WIDTH;
	localparam int CFG_INDEX_WIDTH = $clog2(CHANNELS);
	localparam int KIND_WIDTH      = $clog2(CHANNELS);

	localparam logic [SETTING_WIDTH-1:0] SETTING_RESET = SETTING_WIDTH'(65535);

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [KIND_WIDTH-1:0] KIND_YAW_ANG   = KIND_WIDTH'(0);
	localparam logic [KIND_WIDTH-1:0] KIND_YAW_VEL   = KIND_WIDTH'(1);
	localparam logic [KIND_WIDTH-1:0] KIND_ROLL_ANG  = KIND_WIDTH'(2);
	localparam logic [KIND_WIDTH-1:0] KIND_ROLL_VEL  = KIND_WIDTH'(3);
	localparam logic [KIND_WIDTH-1:0] KIND_PITCH_ANG = KIND_WIDTH'(4);
	localparam logic [KIND_WIDTH-1:0] KIND_PITCH_VEL = KIND_WIDTH'(5);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic        [SAMPLE_WIDTH-1:0] limit_t;
	typedef logic        [TIMER_WIDTH-1:0]  timer_t;
	typedef logic        [SETTING_WIDTH-1:0] setting_t;
	typedef setting_t [CHANNELS-1:0] setting_arr_t;
	typedef timer_t   [CHANNELS-1:0] timer_arr_t;

	typedef struct packed {
		logic                             command;
		logic [STEP_WIDTH-1:0]            dt_us;
		logic [CHANNELS-1:0][SAMPLE_WIDTH-1:0] readings;
	} in_word_t;

	typedef struct packed {
		logic                  failed;
		logic [KIND_WIDTH-1:0] kind;
		sample_t               value;
		limit_t                limit;
	} result_t;

endpackage

>>> hw/rtl/almp_cfg_regs.sv
// ----------------------------------------------------------------------------
// almp_cfg_regs: channel setting registers
// Holds the limit and persistence setting of each channel; indexes beyond
// the channel count are ignored.
// ----------------------------------------------------------------------------
module almp_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [almp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [almp_pkg::SETTING_WIDTH-1:0]    cfg_data,
	output almp_pkg::setting_arr_t                settings
);
	import almp_pkg::*;

	setting_arr_t setting_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				setting_q[ch] <= SETTING_RESET;
			end
		end else if (cfg_write) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (cfg_index == CFG_INDEX_WIDTH'(ch)) begin
					setting_q[ch] <= cfg_data;
				end
			end
		end
	end

	assign settings = setting_q;

endmodule

>>> hw/rtl/almp_check.sv
// ----------------------------------------------------------------------------
// almp_check: persistence timers and limit evaluation
// Compares each channel's magnitude with its limit, advances or clears the
// timers up to the first failing channel, which it picks in priority order.
// ----------------------------------------------------------------------------
module almp_check (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_en,
	input  almp_pkg::in_word_t     word,
	input  almp_pkg::setting_arr_t settings,
	output almp_pkg::result_t      result
);
	import almp_pkg::*;

	timer_arr_t                         timer_q;
	timer_arr_t                         timer_d;
	timer_arr_t                         timer_sat;
	logic [CHANNELS-1:0]                exceed;
	logic [CHANNELS-1:0]                hit;
	logic [CHANNELS-1:0][SAMPLE_WIDTH:0] mag;
	logic [CHANNELS-1:0][TIMER_WIDTH:0]  sum;
	result_t                            res;

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (word.readings[ch][SAMPLE_WIDTH-1]) begin
				mag[ch] = (SAMPLE_WIDTH+1)'(0)
					- {word.readings[ch][SAMPLE_WIDTH-1], word.readings[ch]};
			end else begin
				mag[ch] = {1'b0, word.readings[ch]};
			end
			exceed[ch] = mag[ch] > {1'b0, settings[ch][SAMPLE_WIDTH-1:0]};
			sum[ch] = {1'b0, timer_q[ch]} + (TIMER_WIDTH+1)'(word.dt_us);
			timer_sat[ch] = sum[ch][TIMER_WIDTH] ? '1 : sum[ch][TIMER_WIDTH-1:0];
			hit[ch] = exceed[ch]
				&& (timer_sat[ch] >= settings[ch][SETTING_WIDTH-1:SAMPLE_WIDTH]);
		end
	end

	always_comb begin
		logic stop;
		stop    = 1'b0;
		res     = '0;
		timer_d = timer_q;
		if (word.command == CMD_CLEAR) begin
			timer_d = '0;
		end else begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (!stop) begin
					if (exceed[ch]) begin
						timer_d[ch] = timer_sat[ch];
						if (hit[ch]) begin
							stop       = 1'b1;
							res.failed = 1'b1;
							res.kind   = KIND_WIDTH'(ch);
							res.value  = sample_t'(word.readings[ch]);
							res.limit  = settings[ch][SAMPLE_WIDTH-1:0];
						end
					end else begin
						timer_d[ch] = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (upd_en) begin
			timer_q <= timer_d;
		end
	end

	assign result = res;

`ifndef ASSERT_OFF
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && word.command == CMD_CLEAR) |=> (timer_q == '0))
		else $error("timers not cleared by clear command");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_en |=> $stable(timer_q))
		else $error("timers changed without an update");

	a_first_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && word.command == CMD_CHECK && !exceed[0]) |=> (timer_q[0] == '0))
		else $error("first channel timer not cleared within limit");
`endif

endmodule

>>> hw/rtl/attitude_limit_persistence_monitor.sv
// ----------------------------------------------------------------------------
// attitude_limit_persistence_monitor: attitude limit persistence monitor
// Top level: input register, evaluation pass and result register.
// ----------------------------------------------------------------------------
// The monitor takes one word per clock cycle while its result is not stalled.
// An accepted word is held in the input register and evaluated against the
// six channel timers in one pass; its result and out_valid are registered
// when the word leaves the input register, which also updates the timers. A
// stalled result holds the input register, so at most one more word enters
// before in_ready drops. Settings are to be written through the plain write
// port while no word is in flight; the block itself does not enforce this.
module attitude_limit_persistence_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [almp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [almp_pkg::SETTING_WIDTH-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 command,
	input  logic [almp_pkg::STEP_WIDTH-1:0]      dt_us,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] yaw_ang,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] yaw_vel,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] roll_ang,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] roll_vel,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] pitch_ang,
	input  logic signed [almp_pkg::SAMPLE_WIDTH-1:0] pitch_vel,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 failed,
	output logic [almp_pkg::KIND_WIDTH-1:0]      failure_kind,
	output logic signed [almp_pkg::SAMPLE_WIDTH-1:0] reported_value,
	output logic [almp_pkg::SAMPLE_WIDTH-1:0]    reported_limit
);
	import almp_pkg::*;

	setting_arr_t settings;
	in_word_t     in_word;
	in_word_t     word_s1;
	logic         valid_s1;
	logic         adv;
	result_t      res;
	result_t      res_s2;
	logic         valid_s2;

	always_comb begin
		in_word.command   = command;
		in_word.dt_us     = dt_us;
		in_word.readings  = '0;
		in_word.readings[KIND_YAW_ANG]   = yaw_ang;
		in_word.readings[KIND_YAW_VEL]   = yaw_vel;
		in_word.readings[KIND_ROLL_ANG]  = roll_ang;
		in_word.readings[KIND_ROLL_VEL]  = roll_vel;
		in_word.readings[KIND_PITCH_ANG] = pitch_ang;
		in_word.readings[KIND_PITCH_VEL] = pitch_vel;
	end

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	almp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.settings  (settings)
	);

	almp_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (adv),
		.word     (word_s1),
		.settings (settings),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign failed         = res_s2.failed;
	assign failure_kind   = res_s2.kind;
	assign reported_value = res_s2.value;
	assign reported_limit = res_s2.limit;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");

	a_pass_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !failed) |->
			(failure_kind == '0 && reported_value == '0 && reported_limit == '0))
		else $error("passing result carries nonzero fields");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (failure_kind <= KIND_PITCH_VEL))
		else $error("failure kind out of range");
`endif

endmodule

>>> tb/attitude_limit_persistence_monitor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attitude_limit_persistence_monitor_checker: result checker of the monitor
// Watches the setting writes and both word channels, keeps its own copy of
// the limits, persistences and channel timers, predicts the result word of
// every accepted sample and compares each delivered result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module attitude_limit_persistence_monitor_checker
	import almp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  setting_t                   cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       command,
	input  logic [STEP_WIDTH-1:0]      dt_us,
	input  sample_t                    yaw_ang,
	input  sample_t                    yaw_vel,
	input  sample_t                    roll_ang,
	input  sample_t                    roll_vel,
	input  sample_t                    pitch_ang,
	input  sample_t                    pitch_vel,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       failed,
	input  logic [KIND_WIDTH-1:0]      failure_kind,
	input  sample_t                    reported_value,
	input  limit_t                     reported_limit,
	output int                         mismatches,
	output int                         pending,
	output int                         checked,
	output int                         flagged
);

	setting_t channel_setting [CHANNELS];
	timer_t   channel_timer [CHANNELS];
	result_t  predicted_reports [$];
	result_t  want;
	result_t  got;
	sample_t  readings [CHANNELS];

	function automatic result_t judge_sample(input logic cmd,
			input logic [STEP_WIDTH-1:0] dt, input sample_t reading [CHANNELS]);
		result_t report;
		logic [SAMPLE_WIDTH:0] magnitude;
		limit_t limit;
		timer_t persistence;
		logic [TIMER_WIDTH:0] sum;
		bit done;
		int ch;
		report = '0;
		done = 1'b0;
		if (cmd == CMD_CLEAR) begin
			for (ch = 0; ch < CHANNELS; ch++)
				channel_timer[ch] = '0;
			return report;
		end
		for (ch = 0; ch < CHANNELS && !done; ch++) begin
			limit = channel_setting[ch][SAMPLE_WIDTH-1:0];
			persistence = channel_setting[ch][SETTING_WIDTH-1:SAMPLE_WIDTH];
			magnitude = {1'b0, reading[ch]};
			if (reading[ch][SAMPLE_WIDTH-1])
				magnitude = (SAMPLE_WIDTH+1)'(1 << SAMPLE_WIDTH) - magnitude;
			if (magnitude > {1'b0, limit}) begin
				sum = {1'b0, channel_timer[ch]} + (TIMER_WIDTH+1)'(dt);
				channel_timer[ch] = sum[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}}
					: sum[TIMER_WIDTH-1:0];
				if (channel_timer[ch] >= persistence) begin
					report.failed = 1'b1;
					report.kind = KIND_WIDTH'(ch);
					report.value = reading[ch];
					report.limit = limit;
					done = 1'b1;
				end
			end else begin
				channel_timer[ch] = '0;
			end
		end
		return report;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				channel_setting[ch] = SETTING_RESET;
				channel_timer[ch] = '0;
			end
			predicted_reports.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			flagged = 0;
		end else begin
			if (cfg_write && cfg_index < CHANNELS)
				channel_setting[cfg_index] = cfg_data;
			if (out_valid && out_ready) begin
				got = {failed, failure_kind, reported_value, reported_limit};
				if (predicted_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"checker: unexpected result word ",
							"failed=%0b kind=%0d value=%0d limit=%0d"},
							got.failed, got.kind, got.value, got.limit);
				end else begin
					want = predicted_reports.pop_front();
					checked++;
					if (want.failed)
						flagged++;
					if (got.failed !== want.failed || got.kind !== want.kind
							|| got.value !== want.value || got.limit !== want.limit) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"checker: word %0d expected failed=%0b kind=%0d ",
								"value=%0d limit=%0d, got failed=%0b kind=%0d ",
								"value=%0d limit=%0d"},
								checked, want.failed, want.kind, want.value, want.limit,
								got.failed, got.kind, got.value, got.limit);
					end
				end
			end
			if (in_valid && in_ready) begin
				readings[0] = yaw_ang;
				readings[1] = yaw_vel;
				readings[2] = roll_ang;
				readings[3] = roll_vel;
				readings[4] = pitch_ang;
				readings[5] = pitch_vel;
				predicted_reports.push_back(judge_sample(command, dt_us, readings));
			end
			pending = predicted_reports.size();
		end
	end

endmodule

>>> tb/attitude_limit_persistence_monitor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attitude_limit_persistence_monitor_tb: testbench of the attitude monitor
// Loads channel settings while the monitor is idle, sends a directed set of
// samples and clear commands, then random samples under several pacing
// mixes. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module attitude_limit_persistence_monitor_tb;
	import almp_pkg::*;

	localparam int IDLE_LIMIT       = 5000;
	localparam int PHASE_WORDS      = 75;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	setting_t                   cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       command = CMD_CHECK;
	logic [STEP_WIDTH-1:0]      dt_us = '0;
	sample_t                    yaw_ang = '0;
	sample_t                    yaw_vel = '0;
	sample_t                    roll_ang = '0;
	sample_t                    roll_vel = '0;
	sample_t                    pitch_ang = '0;
	sample_t                    pitch_vel = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       failed;
	logic [KIND_WIDTH-1:0]      failure_kind;
	sample_t                    reported_value;
	limit_t                     reported_limit;

	int mismatches;
	int pending;
	int checked;
	int flagged;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int clears_sent = 0;
	int setting_loads = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	attitude_limit_persistence_monitor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.dt_us          (dt_us),
		.yaw_ang        (yaw_ang),
		.yaw_vel        (yaw_vel),
		.roll_ang       (roll_ang),
		.roll_vel       (roll_vel),
		.pitch_ang      (pitch_ang),
		.pitch_vel      (pitch_vel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.failed         (failed),
		.failure_kind   (failure_kind),
		.reported_value (reported_value),
		.reported_limit (reported_limit)
	);

	attitude_limit_persistence_monitor_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.dt_us          (dt_us),
		.yaw_ang        (yaw_ang),
		.yaw_vel        (yaw_vel),
		.roll_ang       (roll_ang),
		.roll_vel       (roll_vel),
		.pitch_ang      (pitch_ang),
		.pitch_vel      (pitch_vel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.failed         (failed),
		.failure_kind   (failure_kind),
		.reported_value (reported_value),
		.reported_limit (reported_limit),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.flagged        (flagged)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic cmd, input logic [STEP_WIDTH-1:0] dt,
			input sample_t ya, input sample_t yr, input sample_t ra, input sample_t rr,
			input sample_t pa, input sample_t pr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		dt_us <= dt;
		yaw_ang <= ya;
		yaw_vel <= yr;
		roll_ang <= ra;
		roll_vel <= rr;
		pitch_ang <= pa;
		pitch_vel <= pr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Indexes past the last channel are written too; the monitor must ignore them.
	task automatic program_settings(input setting_t values [CHANNELS]);
		int idx;
		for (idx = 0; idx < CHANNELS + 2; idx++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_INDEX_WIDTH'(idx);
			if (idx < CHANNELS)
				cfg_data <= values[idx];
			else
				cfg_data <= setting_t'({$urandom(), $urandom()});
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		setting_loads++;
	endtask

	function automatic setting_t random_setting();
		limit_t lim;
		timer_t persist;
		case ($urandom_range(9))
			0: lim = '0;
			1: lim = '1;
			2: lim = 16'd32767;
			3: lim = 16'd32768;
			default: lim = limit_t'($urandom_range(20000));
		endcase
		case ($urandom_range(7))
			0: persist = '0;
			1: persist = '1;
			2: persist = $urandom();
			default: persist = timer_t'($urandom_range(150000));
		endcase
		return {persist, lim};
	endfunction

	function automatic sample_t pick_reading(input limit_t lim);
		int roll;
		int mag;
		roll = $urandom_range(99);
		if (roll < 35 && lim < 16'd32768) begin
			if ($urandom_range(1) == 0)
				mag = int'(lim) + 1 + $urandom_range(2);
			else
				mag = $urandom_range(32768, int'(lim) + 1);
			if (mag >= 32768)
				return sample_t'(-32768);
			return ($urandom_range(1) == 0) ? sample_t'(mag) : sample_t'(-mag);
		end
		if (roll < 50 && lim <= 16'd32768)
			return ($urandom_range(1) == 0) ? sample_t'(int'(lim)) : sample_t'(-int'(lim));
		return sample_t'($urandom());
	endfunction

	function automatic logic [STEP_WIDTH-1:0] pick_step();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return STEP_WIDTH'($urandom());
		endcase
	endfunction

	task automatic run_phase(input int send_pct, input int stall_pct);
		setting_t values [CHANNELS];
		sample_t r [CHANNELS];
		int n;
		int ch;
		for (ch = 0; ch < CHANNELS; ch++)
			values[ch] = random_setting();
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		program_settings(values);
		for (n = 0; n < PHASE_WORDS; n++) begin
			for (ch = 0; ch < CHANNELS; ch++)
				r[ch] = pick_reading(values[ch][SAMPLE_WIDTH-1:0]);
			send_sample(($urandom_range(99) < 4) ? CMD_CLEAR : CMD_CHECK, pick_step(),
				r[0], r[1], r[2], r[3], r[4], r[5]);
		end
		drain();
	endtask

	initial begin
		setting_t values [CHANNELS];
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(CMD_CHECK, 16'hFFFF, -32768, -32768, -32768, -32768, -32768, -32768);
		drain();

		values[0] = {32'd0, 16'd100};
		values[1] = {32'd250, 16'd100};
		values[2] = {32'd0, 16'd0};
		values[3] = {32'd0, 16'd1000};
		values[4] = {32'd0, 16'd32767};
		values[5] = {32'd10, 16'd200};
		program_settings(values);
		send_sample(CMD_CHECK, 16'd0, 0, 0, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'hFFFF, 100, -100, 0, -1000, 32767, 200);
		send_sample(CMD_CHECK, 16'd7, 101, 0, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd7, -101, 0, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd100, 0, -200, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd100, 0, -200, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd50, 0, -200, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd1, 0, 100, 1, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd1, 0, 0, 0, 1001, 0, 0);
		send_sample(CMD_CHECK, 16'd1, 0, 0, 0, -1000, -32768, 0);
		send_sample(CMD_CHECK, 16'd5, 0, 0, 0, 0, 32767, -32768);
		send_sample(CMD_CHECK, 16'd5, 0, 0, 0, 0, 32767, -32768);
		send_sample(CMD_CHECK, 16'd200, 0, 300, 0, 0, 0, 0);
		send_sample(CMD_CLEAR, 16'hFFFF, 32767, -32768, 32767, -32768, 32767, -32768);
		send_sample(CMD_CHECK, 16'd200, 0, 300, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'd10, 500, 300, 0, 0, 0, 201);
		send_sample(CMD_CHECK, 16'd50, 0, 300, 0, 0, 0, 0);
		send_sample(CMD_CHECK, 16'hFFFF, 0, 0, -1, 0, 0, 0);
		drain();

		for (n = 0; n < 8; n++) begin
			case (n / 2)
				0: run_phase(0, 0);
				1: run_phase(74, 0);
				2: run_phase(0, 74);
				default: run_phase(37, 37);
			endcase
		end

		$display("Sent %0d words (%0d clear commands) over %0d setting loads %s",
			words_sent, clears_sent, setting_loads, "and four pacing mixes.");
		$display("Checked %0d result words, %0d reporting a limit failure; %s",
			checked, flagged, $sformatf("%0d mismatches, %0d left waiting.",
			mismatches, pending));
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/almp_pkg.sv
hw/rtl/almp_cfg_regs.sv
hw/rtl/almp_check.sv
hw/rtl/attitude_limit_persistence_monitor.sv
tb/attitude_limit_persistence_monitor_checker.sv
tb/attitude_limit_persistence_monitor_tb.sv
